[rtl/path_normalizer_top_defines.svh]
// Assertion helpers for the path normalizer.
`ifndef PATH_NORMALIZER_TOP_DEFINES_SVH
`define PATH_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pn_pkg;

  localparam int MAX_LEN    = 256;
  localparam int MAX_LEVELS = 50;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int POS_W  = $clog2(MAX_LEN + 2);
  localparam int SUM_W  = POS_W + 1;
  localparam int DEP_W  = $clog2(MAX_LEVELS);
  localparam int BEAT_W = 64;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LEVELS   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] DOTS_NONE = 2'd0;
  localparam logic [1:0] DOTS_ONE  = 2'd1;
  localparam logic [1:0] DOTS_TWO  = 2'd2;
  localparam logic [1:0] DOTS_WORD = 2'd3;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_CHAR  = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd3;
  localparam logic [3:0] OP_POP   = 4'd4;
  localparam logic [3:0] OP_DD    = 4'd5;
  localparam logic [3:0] OP_END   = 4'd6;
  localparam logic [3:0] OP_RD    = 4'd7;
  localparam logic [3:0] OP_CAP   = 4'd8;
  localparam logic [3:0] OP_TAKEN = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic       flag;
  } cmd_t;

  typedef struct packed {
    logic need_close;
    logic pop;
    logic dd;
    logic last_item;
    logic end_close;
    logic direct;
    logic beat_ready;
    logic beat_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/pn_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       end_of_path;
  modport source (output valid, char_code, char_present, end_of_path, input ready);
  modport sink (input valid, char_code, char_present, end_of_path, output ready);
endinterface

interface pn_out_if;
  import pn_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEAT_W-1:0] out_bytes;
  logic [3:0]        byte_count;
  logic              last_beat;
  logic [1:0]        status;
  logic [8:0]        total_length;
  modport source (output valid, out_bytes, byte_count, last_beat, status, total_length,
                  input ready);
  modport sink (input valid, out_bytes, byte_count, last_beat, status, total_length,
                output ready);
endinterface

interface pn_cfg_if;
  logic valid;
  logic ready;
  logic backslash_separates;
  modport source (output valid, backslash_separates, input ready);
  modport sink (input valid, backslash_separates, output ready);
endinterface

`default_nettype wire

[rtl/pn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/pn_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module pn_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pn_pkg::cmd_t       cmd,
  output pn_pkg::sts_t            sts,
  input  wire logic [7:0]         in_char,
  input  wire logic               in_present,
  input  wire logic               in_last,
  input  wire logic               cfg_we,
  input  wire logic               cfg_bs,
  output logic [pn_pkg::BEAT_W-1:0] beat_bytes,
  output logic [3:0]              beat_count,
  output logic                    beat_last,
  output logic [1:0]              beat_status,
  output logic [8:0]              beat_total
);
  import pn_pkg::*;

  logic [7:0]        c_r;
  logic              present_r, last_r;
  logic [POS_W-1:0]  wp_r, wp_nxt, clen_r, clen_nxt, rd_pos_r, rd_pos_nxt;
  logic [1:0]        dots_r, dots_nxt, err_r, err_nxt;
  logic [DEP_W-1:0]  depth_r, depth_nxt;
  logic              abs_r, abs_nxt, first_r, first_nxt, bs_r;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              blast_r, blast_nxt;
  logic [1:0]        bstat_r, bstat_nxt;
  logic [8:0]        btot_r, btot_nxt;

  logic              we, re, s_we, s_re;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata, rdata;
  logic [DEP_W-1:0]  s_waddr, s_raddr;
  logic [POS_W-1:0]  s_rdata;

  logic              sep, take;
  logic [SUM_W-1:0]  idx, wp_ext, wp_dd;

  assign sep    = (c_r == CH_SLASH) || (bs_r && (c_r == CH_BSLASH));
  assign take   = present_r && (err_r == ST_OK);
  assign wp_ext = SUM_W'(wp_r);
  assign idx    = wp_ext + SUM_W'(clen_r);
  assign wp_dd  = wp_ext + SUM_W'(3);

  always_comb begin
    wp_nxt     = wp_r;
    clen_nxt   = clen_r;
    dots_nxt   = dots_r;
    err_nxt    = err_r;
    depth_nxt  = depth_r;
    abs_nxt    = abs_r;
    first_nxt  = first_r;
    rd_pos_nxt = rd_pos_r;
    beat_nxt   = beat_r;
    cnt_nxt    = cnt_r;
    blast_nxt  = blast_r;
    bstat_nxt  = bstat_r;
    btot_nxt   = btot_r;
    we         = 1'b0;
    waddr      = wp_r[ADDR_W-1:0];
    wdata      = CH_DOT;
    re         = 1'b0;
    s_we       = 1'b0;
    s_waddr    = depth_r;
    s_re       = 1'b0;
    s_raddr    = depth_r - 1'b1;
    case (cmd.op)
      OP_CHAR: begin
        if (take) begin
          first_nxt = 1'b0;
          if (first_r && sep) begin
            abs_nxt = 1'b1;
            we      = 1'b1;
            waddr   = '0;
            wdata   = CH_SLASH;
            wp_nxt  = POS_W'(1);
          end else if (!sep) begin
            if (clen_r == '0) begin
              dots_nxt = (c_r == CH_DOT) ? DOTS_ONE : DOTS_WORD;
            end else if (dots_r != DOTS_WORD) begin
              dots_nxt = (c_r == CH_DOT) ? dots_r + 2'd1 : DOTS_WORD;
            end
            if (idx < SUM_W'(MAX_LEN)) begin
              we    = 1'b1;
              waddr = idx[ADDR_W-1:0];
              wdata = c_r;
            end
            if (idx <= SUM_W'(MAX_LEN)) begin
              clen_nxt = clen_r + 1'b1;
            end
          end
        end
      end
      OP_CLOSE: begin
        clen_nxt = '0;
        dots_nxt = DOTS_NONE;
        if (dots_r == DOTS_TWO) begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - 1'b1;
            s_re      = 1'b1;
          end else if (abs_r) begin
            wp_nxt = POS_W'(1);
          end else if (wp_dd > SUM_W'(MAX_LEN)) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            we     = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
        end else if (dots_r != DOTS_ONE) begin
          if ((DEP_W + 1)'(depth_r) + 1'b1 >= (DEP_W + 1)'(MAX_LEVELS)) begin
            err_nxt = ST_LEVELS;
          end else if (idx > SUM_W'(MAX_LEN)) begin
            err_nxt = ST_OVERFLOW;
          end else begin
            s_we      = 1'b1;
            depth_nxt = depth_r + 1'b1;
            wp_nxt    = idx[POS_W-1:0];
            if (cmd.flag) begin
              if (idx < SUM_W'(MAX_LEN)) begin
                we     = 1'b1;
                waddr  = idx[ADDR_W-1:0];
                wdata  = CH_SLASH;
                wp_nxt = idx[POS_W-1:0] + 1'b1;
              end else begin
                err_nxt = ST_OVERFLOW;
              end
            end
          end
        end
      end
      OP_POP: begin
        wp_nxt = s_rdata;
      end
      OP_DD: begin
        we     = 1'b1;
        wdata  = cmd.flag ? CH_SLASH : CH_DOT;
        wp_nxt = wp_r + 1'b1;
      end
      OP_END: begin
        beat_nxt   = '0;
        cnt_nxt    = '0;
        blast_nxt  = 1'b0;
        bstat_nxt  = err_r;
        btot_nxt   = 9'(wp_r);
        rd_pos_nxt = '0;
        if (err_r != ST_OK) begin
          blast_nxt = 1'b1;
          btot_nxt  = '0;
        end else if (wp_r == '0) begin
          beat_nxt  = BEAT_W'({CH_SLASH, CH_DOT});
          cnt_nxt   = 4'd2;
          blast_nxt = 1'b1;
          btot_nxt  = 9'd2;
        end
      end
      OP_RD: begin
        re = 1'b1;
      end
      OP_CAP: begin
        beat_nxt[{cnt_r[2:0], 3'b000} +: 8] = rdata;
        cnt_nxt    = cnt_r + 1'b1;
        rd_pos_nxt = rd_pos_r + 1'b1;
        if (rd_pos_r + 1'b1 == wp_r) begin
          blast_nxt = 1'b1;
        end
      end
      OP_TAKEN: begin
        beat_nxt = '0;
        cnt_nxt  = '0;
        if (blast_r) begin
          wp_nxt    = '0;
          clen_nxt  = '0;
          dots_nxt  = DOTS_NONE;
          depth_nxt = '0;
          abs_nxt   = 1'b0;
          first_nxt = 1'b1;
          err_nxt   = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.need_close = take && sep && !first_r && (clen_r != '0);
    sts.pop        = (dots_r == DOTS_TWO) && (depth_r != '0);
    sts.dd         = (dots_r == DOTS_TWO) && (depth_r == '0) && !abs_r &&
                     (wp_dd <= SUM_W'(MAX_LEN));
    sts.last_item  = last_r;
    sts.end_close  = (err_r == ST_OK) && (clen_r != '0);
    sts.direct     = (err_r != ST_OK) || (wp_r == '0);
    sts.beat_ready = (cnt_r == 4'd7) || (rd_pos_r + 1'b1 == wp_r);
    sts.beat_last  = blast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      clen_r  <= '0;
      dots_r  <= DOTS_NONE;
      err_r   <= ST_OK;
      depth_r <= '0;
      abs_r   <= 1'b0;
      first_r <= 1'b1;
      bs_r    <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      clen_r  <= clen_nxt;
      dots_r  <= dots_nxt;
      err_r   <= err_nxt;
      depth_r <= depth_nxt;
      abs_r   <= abs_nxt;
      first_r <= first_nxt;
      if (cfg_we) begin
        bs_r <= cfg_bs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      c_r       <= in_char;
      present_r <= in_present;
      last_r    <= in_last;
    end
    rd_pos_r <= rd_pos_nxt;
    beat_r   <= beat_nxt;
    cnt_r    <= cnt_nxt;
    blast_r  <= blast_nxt;
    bstat_r  <= bstat_nxt;
    btot_r   <= btot_nxt;
  end

  pn_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_path_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_pos_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  pn_ram #(.WIDTH(POS_W), .DEPTH(MAX_LEVELS)) u_level_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (wp_r),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign beat_bytes  = beat_r;
  assign beat_count  = cnt_r;
  assign beat_last   = blast_r;
  assign beat_status = bstat_r;
  assign beat_total  = btot_r;

endmodule

`default_nettype wire

[rtl/pn_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pn_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire pn_pkg::sts_t sts,
  output pn_pkg::cmd_t      cmd
);
  import pn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHAR  = 4'd1;
  localparam logic [3:0] S_CLOSE = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_DD2   = 4'd4;
  localparam logic [3:0] S_DD3   = 4'd5;
  localparam logic [3:0] S_END   = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CAP   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       sep_r, sep_nxt;
  logic [3:0] after_close;

  assign after_close = sts.last_item ? S_END : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    sep_nxt   = sep_r;
    cmd       = '{op: OP_NONE, flag: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.op = OP_CHAR;
        if (sts.need_close) begin
          sep_nxt   = 1'b1;
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = after_close;
        end
      end
      S_CLOSE: begin
        cmd = '{op: OP_CLOSE, flag: sep_r};
        if (sts.pop) begin
          state_nxt = S_POP;
        end else if (sts.dd) begin
          state_nxt = S_DD2;
        end else begin
          state_nxt = after_close;
        end
      end
      S_POP: begin
        cmd.op    = OP_POP;
        state_nxt = after_close;
      end
      S_DD2: begin
        cmd       = '{op: OP_DD, flag: 1'b0};
        state_nxt = S_DD3;
      end
      S_DD3: begin
        cmd       = '{op: OP_DD, flag: 1'b1};
        state_nxt = after_close;
      end
      S_END: begin
        if (sts.end_close) begin
          sep_nxt   = 1'b0;
          state_nxt = S_CLOSE;
        end else begin
          cmd.op    = OP_END;
          state_nxt = sts.direct ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.op    = OP_CAP;
        state_nxt = sts.beat_ready ? S_OUT : S_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.op    = OP_TAKEN;
          state_nxt = sts.beat_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sep_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sep_r   <= sep_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/path_normalizer_top.sv]
// Each word is latched while idle and handled in the character state; a separator ending
// a component adds the close state, a climbing ".." the pop state and a relative "../" the
// dot and slash states. The last word adds the end state, a read and a capture per byte
// and an output state per beat. No word is taken until the last is done and flushed.
// Reset (rst_n low, synchronous) clears control state and the backslash option; the
// path and level RAMs are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "path_normalizer_top_defines.svh"

module path_normalizer_top (
  input  wire logic clk,
  input  wire logic rst_n,
  pn_in_if.sink     in_ch,
  pn_out_if.source  out_ch,
  pn_cfg_if.sink    cfg_ch
);
  import pn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The configuration register is always writable; writes must only happen while idle, unenforced by the block.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences one input word through character handling, component
  // closing and, on the last word, the beat-by-beat flush of the path buffer.
  pn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the path and level RAMs, the component trackers and the
  // output beat register, which stays stable while a beat waits.
  pn_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_char     (in_ch.char_code),
    .in_present  (in_ch.char_present),
    .in_last     (in_ch.end_of_path),
    .cfg_we      (cfg_ch.valid),
    .cfg_bs      (cfg_ch.backslash_separates),
    .beat_bytes  (out_ch.out_bytes),
    .beat_count  (out_ch.byte_count),
    .beat_last   (out_ch.last_beat),
    .beat_status (out_ch.status),
    .beat_total  (out_ch.total_length)
  );

  // A path is fully flushed before another word is taken.
  `PN_ASSERT_NOW(a_no_overlap, out_ch.valid, !in_ch.ready, "input taken during flush")
  // An accepted input word is always processed further before the input is ready again.
  `PN_ASSERT_NEXT(a_two_cycles, in_ch.valid && in_ch.ready, !in_ch.ready,
                  "input ready right after accept")
  // Error results carry no bytes and no length.
  `PN_ASSERT_NOW(a_err_empty, out_ch.valid && out_ch.status != ST_OK,
                 out_ch.byte_count == 4'd0 && out_ch.total_length == 9'd0 && out_ch.last_beat,
                 "error beat not empty")
  // A beat never carries more than eight bytes, and only a final beat is short.
  `PN_ASSERT_NOW(a_beat_size, out_ch.valid && !out_ch.last_beat,
                 out_ch.byte_count == 4'd8, "short beat before the last")

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pn_pkg::*;

  // One expected word on the result channel.
  typedef struct {
    logic [BEAT_W-1:0] bytes;
    logic [3:0]        count;
    logic              last;
    logic [1:0]        status;
    logic [8:0]        total;
  } beat_t;

  // One row of the directed table. Rows with typed set carry the single result
  // word that is obvious by inspection; all other rows rely on the predictor.
  typedef struct {
    logic [7:0] code;
    logic       present;
    logic       eop;
    logic       typed;
    beat_t      word;
  } row_t;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 700;
  localparam int IDLE_LIMIT   = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  pn_in_if  in_ch ();
  pn_out_if out_ch ();
  pn_cfg_if cfg_ch ();

  path_normalizer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // The predictor keeps its own copy of the normalizer state and the option bit.
  logic [7:0] norm_buf [MAX_LEN];
  int         level_pos [MAX_LEVELS];
  int         n_levels;
  int         wr_pos;
  int         part_len;
  int         part_dots;
  logic       is_abs;
  logic       at_start;
  logic [1:0] path_err;
  logic       bslash_on;

  beat_t expected_beats [$];
  beat_t predicted [$];

  int errors = 0;
  int beats_seen = 0;
  int paths_done = 0;
  int err_results = 0;
  int items_sent = 0;
  bit stim_done = 0;

  function automatic void clear_norm();
    n_levels  = 0;
    wr_pos    = 0;
    part_len  = 0;
    part_dots = 0;
    is_abs    = 1'b0;
    at_start  = 1'b1;
    path_err  = ST_OK;
  endfunction

  // Closes the component that is being collected; a ".." pops, "." vanishes.
  function automatic void close_part(bit sep_follows);
    if (part_dots == 2) begin
      if (n_levels > 0) begin
        n_levels--;
        wr_pos = level_pos[n_levels];
      end else if (is_abs) begin
        wr_pos = 1;
      end else if (wr_pos + 3 > MAX_LEN) begin
        path_err = ST_OVERFLOW;
      end else begin
        norm_buf[wr_pos]     = CH_DOT;
        norm_buf[wr_pos + 1] = CH_DOT;
        norm_buf[wr_pos + 2] = CH_SLASH;
        wr_pos += 3;
      end
    end else if (part_dots != 1) begin
      if (n_levels + 1 >= MAX_LEVELS) begin
        path_err = ST_LEVELS;
      end else if (wr_pos + part_len > MAX_LEN) begin
        path_err = ST_OVERFLOW;
      end else begin
        level_pos[n_levels] = wr_pos;
        n_levels++;
        wr_pos += part_len;
        if (sep_follows) begin
          if (wr_pos < MAX_LEN) begin
            norm_buf[wr_pos] = CH_SLASH;
            wr_pos++;
          end else begin
            path_err = ST_OVERFLOW;
          end
        end
      end
    end
    part_len  = 0;
    part_dots = 0;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    bit sep;
    int idx;
    sep = (c == CH_SLASH) || (bslash_on && c == CH_BSLASH);
    if (at_start) begin
      at_start = 1'b0;
      if (sep) begin
        is_abs      = 1'b1;
        norm_buf[0] = CH_SLASH;
        wr_pos      = 1;
        return;
      end
    end
    if (sep) begin
      if (part_len > 0) close_part(1'b1);
      return;
    end
    if (part_len == 0) part_dots = (c == CH_DOT) ? 1 : 3;
    else if (part_dots < 3) part_dots = (c == CH_DOT) ? part_dots + 1 : 3;
    idx = wr_pos + part_len;
    if (idx < MAX_LEN) norm_buf[idx] = c;
    if (idx <= MAX_LEN) part_len++;
  endfunction

  // Advances the predictor by one accepted word and leaves its result words
  // in the predicted queue.
  function automatic void normalize_step(logic [7:0] c, logic present, logic eop);
    int len;
    int nbeats;
    int n;
    beat_t b;
    predicted.delete();
    if (present && path_err == ST_OK) take_byte(c);
    if (!eop) return;
    if (path_err == ST_OK && part_len > 0) close_part(1'b0);
    if (path_err != ST_OK) begin
      b.bytes  = '0;
      b.count  = 4'd0;
      b.last   = 1'b1;
      b.status = path_err;
      b.total  = 9'd0;
      predicted.push_back(b);
      clear_norm();
      return;
    end
    if (wr_pos == 0) begin
      norm_buf[0] = CH_DOT;
      norm_buf[1] = CH_SLASH;
      len = 2;
    end else begin
      len = wr_pos;
    end
    nbeats = (len + 7) / 8;
    for (int k = 0; k < nbeats; k++) begin
      n = len - k * 8;
      if (n > 8) n = 8;
      b.bytes = '0;
      for (int i = 0; i < n; i++) b.bytes[8*i +: 8] = norm_buf[k * 8 + i];
      b.count  = n[3:0];
      b.last   = (k + 1 == nbeats);
      b.status = ST_OK;
      b.total  = len[8:0];
      predicted.push_back(b);
    end
    clear_norm();
  endfunction

  // Idle gaps: mostly random from 0 to 15, but now and then a stretch without gaps.
  function automatic int draw_gap(int burst);
    if (burst > 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  int in_burst = 0;

  // Offers one word on the input channel and updates the predictor once it is taken.
  task automatic send_word(logic [7:0] c, logic p, logic e, logic typed, beat_t tw);
    int gap;
    if (in_burst > 0) in_burst--;
    else if ($urandom_range(0, 30) == 0) in_burst = $urandom_range(10, 40);
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.char_present <= p;
    in_ch.end_of_path  <= e;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    normalize_step(c, p, e);
    if (typed) begin
      expected_beats.push_back(tw);
    end else begin
      foreach (predicted[i]) expected_beats.push_back(predicted[i]);
    end
    if (e) paths_done++;
  endtask

  task automatic send_plain(logic [7:0] c, logic p, logic e);
    beat_t none;
    none = '{default: '0};
    send_word(c, p, e, 1'b0, none);
  endtask

  // The option bit is only changed with the block idle: every expected word
  // is back and the block has had time to finish a path that yields nothing.
  task automatic write_option(logic v);
    in_ch.valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid               <= 1'b1;
    cfg_ch.backslash_separates <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    bslash_on = v;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 7) return CH_DOT;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] sep_char();
    return ($urandom_range(0, 2) == 0) ? CH_BSLASH : CH_SLASH;
  endfunction

  // One random path. Most are well-formed sequences of words, dots and
  // separators; some hit the level limit, some overflow, and the rest is noise.
  task automatic send_random_path();
    int mode;
    int nparts;
    int plen;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      if ($urandom_range(0, 2) == 0) send_plain(sep_char(), 1'b1, 1'b0);
      nparts = $urandom_range(0, 6);
      for (int k = 0; k < nparts; k++) begin
        case ($urandom_range(0, 3))
          0: send_plain(CH_DOT, 1'b1, 1'b0);
          1: begin
            send_plain(CH_DOT, 1'b1, 1'b0);
            send_plain(CH_DOT, 1'b1, 1'b0);
          end
          default: begin
            plen = $urandom_range(1, 5);
            repeat (plen) send_plain(word_char(), 1'b1, 1'b0);
          end
        endcase
        repeat ($urandom_range(1, 3)) send_plain(sep_char(), 1'b1, 1'b0);
      end
      send_plain(word_char(), 1'($urandom_range(0, 1)), 1'b1);
    end else if (mode < 78) begin
      nparts = $urandom_range(MAX_LEVELS - 3, MAX_LEVELS + 2);
      for (int k = 0; k < nparts; k++) begin
        send_plain(8'(8'h61 + $urandom_range(0, 25)), 1'b1, 1'b0);
        send_plain(CH_SLASH, 1'b1, 1'b0);
      end
      send_plain(8'h7A, 1'b1, 1'b1);
    end else if (mode < 83) begin
      plen = $urandom_range(MAX_LEN - 16, MAX_LEN + 12);
      if ($urandom_range(0, 1)) send_plain(CH_SLASH, 1'b1, 1'b0);
      repeat (plen) send_plain(word_char() | 8'h40, 1'b1, 1'b0);
      send_plain(CH_SLASH, 1'b1, 1'b1);
    end else begin
      plen = $urandom_range(0, 12);
      repeat (plen) send_plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
      send_plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  function automatic beat_t mk(logic [BEAT_W-1:0] b, int n, int st, int len);
    beat_t w;
    w.bytes  = b;
    w.count  = n[3:0];
    w.last   = 1'b1;
    w.status = st[1:0];
    w.total  = len[8:0];
    return w;
  endfunction

  row_t table_rows [$];

  task automatic build_table();
    beat_t none;
    none = '{default: '0};
    // Empty path: a lone end word without a byte gives "./".
    table_rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, mk(64'h2F2E, 2, ST_OK, 2)});
    // The root alone.
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b1, 1'b1, mk(64'h2F, 1, ST_OK, 1)});
    // A relative ".." with nothing to pop becomes "../".
    table_rows.push_back('{CH_DOT, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b1, 1'b1, mk(64'h2F2E2E, 3, ST_OK, 3)});
    // A ".." at the root of an absolute path stays at the root.
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b1, 1'b1, mk(64'h2F, 1, ST_OK, 1)});
    // Collapsed separators, a dropped ".", a word without a byte mid path,
    // and the byte extremes.
    table_rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{8'h00, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{8'hAA, 1'b0, 1'b0, 1'b0, none});
    table_rows.push_back('{8'hFF, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_SLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{8'h55, 1'b1, 1'b1, 1'b0, none});
    // Backslash with the option off is an ordinary byte.
    table_rows.push_back('{CH_BSLASH, 1'b1, 1'b0, 1'b0, none});
    table_rows.push_back('{CH_DOT, 1'b1, 1'b1, 1'b0, none});
  endtask

  // Stimulus: reset, the directed table, then random phases with the option
  // toggled between them, extremes included.
  initial begin
    in_ch.valid                <= 1'b0;
    in_ch.char_code            <= 8'h00;
    in_ch.char_present         <= 1'b0;
    in_ch.end_of_path          <= 1'b0;
    cfg_ch.valid               <= 1'b0;
    cfg_ch.backslash_separates <= 1'b0;
    bslash_on = 1'b0;
    clear_norm();
    build_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i])
      send_word(table_rows[i].code, table_rows[i].present, table_rows[i].eop,
                table_rows[i].typed, table_rows[i].word);
    write_option(1'b1);
    // With the option on, a leading backslash makes the path absolute.
    send_plain(CH_BSLASH, 1'b1, 1'b0);
    send_plain(8'h62, 1'b1, 1'b0);
    send_plain(CH_BSLASH, 1'b1, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      while (items_sent < 140 + ph * 95) send_random_path();
      write_option(ph[0]);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Result side: random back-pressure, with one long hold-off so that the
  // block fills up and stalls its input.
  int out_burst = 0;
  bit held = 0;

  initial begin
    int gap;
    beat_t want;
    out_ch.ready <= 1'b0;
    forever begin
      if (out_burst > 0) out_burst--;
      else if ($urandom_range(0, 30) == 0) out_burst = $urandom_range(10, 40);
      gap = draw_gap(out_burst);
      if (!held && beats_seen >= 30) begin
        held = 1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && rst_n));
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected word bytes=%h count=%0d", $time, out_ch.out_bytes,
                 out_ch.byte_count);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.status != ST_OK) err_results++;
        if (out_ch.out_bytes !== want.bytes || out_ch.byte_count !== want.count ||
            out_ch.last_beat !== want.last || out_ch.status !== want.status ||
            out_ch.total_length !== want.total) begin
          $display("%0t: mismatch expected bytes=%h count=%0d last=%0d status=%0d len=%0d",
                   $time, want.bytes, want.count, want.last, want.status, want.total);
          $display("%0t:          actual bytes=%h count=%0d last=%0d status=%0d len=%0d",
                   $time, out_ch.out_bytes, out_ch.byte_count, out_ch.last_beat,
                   out_ch.status, out_ch.total_length);
          errors++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no word moving on any channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_beats.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // End of run: drain, give the block time to show any stray word, then judge.
  initial begin
    wait (stim_done);
    wait (expected_beats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_beats.size());
      errors++;
    end
    $display("Sent %0d words in %0d paths, checked %0d result words (%0d error results).",
             items_sent, paths_done, beats_seen, err_results);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
